// ===== src/tnst_pkg.sv =====
// Package for the top-N score table: sizes, codes and the tag mask.
// No dependencies; imported by tnst_ram users and top_n_score_table.
`default_nettype none
package tnst_pkg;

  localparam int BANKS      = 8;
  localparam int LIST_LEN   = 10;
  localparam int NAME_BYTES = 8;

  localparam int TOTAL   = BANKS * LIST_LEN;
  localparam int ADDR_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int CNT_W   = $clog2(LIST_LEN + 1);
  localparam int BANK_W  = 3;
  localparam int SLOT_W  = 4;
  localparam int PLACE_W = 4;
  localparam int SCORE_W = 32;
  localparam int TAG_W   = 64;
  localparam int ENTRY_W = SCORE_W + TAG_W;

  localparam logic [TAG_W-1:0] TAG_MASK =
    (NAME_BYTES >= 8) ? {TAG_W{1'b1}} : ((64'd1 << (8 * NAME_BYTES)) - 64'd1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_RANK  = 2'd1;
  localparam logic [1:0] ST_BAD_BANK = 2'd2;
  localparam logic [1:0] ST_BAD_SLOT = 2'd3;

endpackage
`default_nettype wire

// ===== src/tnst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tnst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/top_n_score_table.sv =====
// Top-N score table: per-bank descending (score, tag) lists in one RAM.
// Depends on tnst_pkg and tnst_ram.
// Insert: the scan and shift walk the whole bank, with one RAM read per slot, before the result.
// Read: one RAM read of the requested slot. Bad bank or slot: answered with no RAM read.
// One item at a time; the next is taken the cycle after the result reaches the output register.
// Reset clears control and per-entry valid bits, so every entry reads as zero at once.
`default_nettype none
module top_n_score_table (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              command,
  input  wire logic [tnst_pkg::BANK_W-1:0]       bank,
  input  wire logic signed [tnst_pkg::SCORE_W-1:0] cand_score,
  input  wire logic [tnst_pkg::TAG_W-1:0]        name_tag,
  input  wire logic [tnst_pkg::SLOT_W-1:0]       slot,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [1:0]                             status,
  output logic [tnst_pkg::PLACE_W-1:0]           place,
  output logic signed [tnst_pkg::SCORE_W-1:0]    entry_score,
  output logic [tnst_pkg::TAG_W-1:0]             entry_name
);
  import tnst_pkg::*;

  typedef enum logic [2:0] {IDLE, SCAN, RD_ISSUE, RD_WAIT, RESP} state_t;

  state_t               state;
  logic [ADDR_W-1:0]    base;
  logic [SCORE_W-1:0]   score;
  logic [TAG_W-1:0]     tag;
  logic [SLOT_W-1:0]    slot_r;
  logic [CNT_W-1:0]     rd_cnt;
  logic [CNT_W-1:0]     pd_slot;
  logic                 pd;
  logic                 found;
  logic [ENTRY_W-1:0]   carry;
  logic [1:0]           res_status;
  logic [PLACE_W-1:0]   res_place;
  logic [SCORE_W-1:0]   res_score;
  logic [TAG_W-1:0]     res_name;
  logic [TOTAL-1:0]     vld;
  logic                 rd_vld;

  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  logic [ENTRY_W-1:0]   wdata;
  logic [ADDR_W-1:0]    raddr;
  logic [CNT_W-1:0]     rd_idx;
  logic [ENTRY_W-1:0]   ram_q;
  logic [ENTRY_W-1:0]   rd_data;
  logic [SCORE_W-1:0]   d_score;
  logic [TAG_W-1:0]     d_tag;
  logic                 ranks;
  logic                 last;

  assign in_stall = (state != IDLE);

  assign rd_data = rd_vld ? ram_q : '0;
  assign d_score = rd_data[ENTRY_W-1 -: SCORE_W];
  assign d_tag   = rd_data[TAG_W-1:0];
  assign ranks   = $signed(score) > $signed(d_score);
  assign last    = (pd_slot == CNT_W'(LIST_LEN - 1));

  always_comb begin
    rd_idx = (rd_cnt < CNT_W'(LIST_LEN)) ? rd_cnt : CNT_W'(LIST_LEN - 1);
    if (state == RD_ISSUE) begin
      raddr = base + ADDR_W'(slot_r);
    end else begin
      raddr = base + ADDR_W'(rd_idx);
    end
    we    = (state == SCAN) && pd && (found || ranks);
    waddr = base + ADDR_W'(pd_slot);
    wdata = found ? carry : {score, tag};
  end

  tnst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TOTAL)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    rd_vld <= vld[raddr];
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      pd        <= 1'b0;
      found     <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != RESP) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            base      <= ADDR_W'(int'(bank) * LIST_LEN);
            score     <= cand_score;
            tag       <= name_tag & TAG_MASK;
            slot_r    <= slot;
            rd_cnt    <= '0;
            pd        <= 1'b0;
            found     <= 1'b0;
            res_place <= '0;
            res_score <= '0;
            res_name  <= '0;
            if (int'(bank) >= BANKS) begin
              res_status <= ST_BAD_BANK;
              state      <= RESP;
            end else if (command == CMD_INSERT) begin
              res_status <= ST_OK;
              state      <= SCAN;
            end else if (int'(slot) >= LIST_LEN) begin
              res_status <= ST_BAD_SLOT;
              state      <= RESP;
            end else begin
              res_status <= ST_OK;
              state      <= RD_ISSUE;
            end
          end
        end
        SCAN: begin
          if (rd_cnt < CNT_W'(LIST_LEN)) begin
            rd_cnt  <= rd_cnt + 1'b1;
            pd      <= 1'b1;
            pd_slot <= rd_cnt;
          end else begin
            pd <= 1'b0;
          end
          if (pd) begin
            if (!found && ranks) begin
              found     <= 1'b1;
              res_place <= PLACE_W'(pd_slot);
              carry     <= rd_data;
            end else if (found) begin
              carry <= rd_data;
            end
            if (last) begin
              if (found || ranks) begin
                res_status <= ST_OK;
              end else begin
                res_status <= ST_NO_RANK;
                res_place  <= PLACE_W'(LIST_LEN);
              end
              state <= RESP;
            end
          end
        end
        RD_ISSUE: begin
          state <= RD_WAIT;
        end
        RD_WAIT: begin
          res_status <= ST_OK;
          res_place  <= '0;
          res_score  <= d_score;
          res_name   <= d_tag;
          state      <= RESP;
        end
        RESP: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            place       <= res_place;
            entry_score <= res_score;
            entry_name  <= res_name;
            state       <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
